FILE: hw/rtl/rbsi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rbsi_pkg;

  localparam int unsigned NumAxes  = 3;
  localparam int unsigned QW       = 32;
  localparam int unsigned FracBits = 16;

  typedef logic signed [QW-1:0] q16_t;

  // per-axis slab interval, ordered
  typedef struct packed {
    q16_t t_near;
    q16_t t_far;
  } lane_res_t;

endpackage

`default_nettype wire

FILE: hw/rtl/rbsi_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface rbsi_in_if;
  logic                valid;
  logic                ready;
  rbsi_pkg::q16_t      origin_x;
  rbsi_pkg::q16_t      origin_y;
  rbsi_pkg::q16_t      origin_z;
  rbsi_pkg::q16_t      inv_dir_x;
  rbsi_pkg::q16_t      inv_dir_y;
  rbsi_pkg::q16_t      inv_dir_z;
  rbsi_pkg::q16_t      box_min_x;
  rbsi_pkg::q16_t      box_min_y;
  rbsi_pkg::q16_t      box_min_z;
  rbsi_pkg::q16_t      box_max_x;
  rbsi_pkg::q16_t      box_max_y;
  rbsi_pkg::q16_t      box_max_z;

  modport source (
    output valid, origin_x, origin_y, origin_z, inv_dir_x, inv_dir_y, inv_dir_z,
           box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
    input  ready
  );

  modport sink (
    input  valid, origin_x, origin_y, origin_z, inv_dir_x, inv_dir_y, inv_dir_z,
           box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
    output ready
  );
endinterface

`default_nettype wire

FILE: hw/rtl/rbsi_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface rbsi_out_if;
  logic           valid;
  logic           ready;
  logic           hit;
  rbsi_pkg::q16_t hit_distance;

  modport source (
    output valid, hit, hit_distance,
    input  ready
  );

  modport sink (
    input  valid, hit, hit_distance,
    output ready
  );
endinterface

`default_nettype wire

FILE: hw/rtl/rbsi_lane.sv
`timescale 1ns / 1ps
`default_nettype none

// one axis: slab distances for both corners, three register stages
module rbsi_lane (
  input  wire logic                clk_i,
  input  wire logic                en_i,
  input  wire rbsi_pkg::q16_t      origin_i,
  input  wire rbsi_pkg::q16_t      inv_dir_i,
  input  wire rbsi_pkg::q16_t      box_min_i,
  input  wire rbsi_pkg::q16_t      box_max_i,
  output rbsi_pkg::lane_res_t      res_o
);

  localparam int unsigned DW = rbsi_pkg::QW + 1;
  localparam int unsigned PW = DW + rbsi_pkg::QW;
  localparam int unsigned SW = PW - rbsi_pkg::FracBits;

  logic signed [DW-1:0] d_lo_d, d_hi_d, d_lo_q, d_hi_q;
  rbsi_pkg::q16_t       inv_q;
  logic signed [PW-1:0] p_lo_d, p_hi_d, p_lo_q, p_hi_q;
  rbsi_pkg::q16_t       t_lo, t_hi;
  rbsi_pkg::lane_res_t  res_d, res_q;

  function automatic rbsi_pkg::q16_t sat_q16(input logic signed [PW-1:0] p);
    logic signed [SW-1:0] s;
    logic                 fits;
    s    = SW'(p >>> rbsi_pkg::FracBits);
    // fits when the sign bit of a 32-bit result and all bits above it agree
    fits = (&s[SW-1:rbsi_pkg::QW-1]) | ~(|s[SW-1:rbsi_pkg::QW-1]);
    if (fits) begin
      sat_q16 = s[rbsi_pkg::QW-1:0];
    end else if (s[SW-1]) begin
      sat_q16 = {1'b1, {(rbsi_pkg::QW-1){1'b0}}};
    end else begin
      sat_q16 = {1'b0, {(rbsi_pkg::QW-1){1'b1}}};
    end
  endfunction

  assign d_lo_d = DW'($signed(box_min_i)) - DW'($signed(origin_i));
  assign d_hi_d = DW'($signed(box_max_i)) - DW'($signed(origin_i));

  assign p_lo_d = PW'(d_lo_q) * PW'(inv_q);
  assign p_hi_d = PW'(d_hi_q) * PW'(inv_q);

  assign t_lo = sat_q16(p_lo_q);
  assign t_hi = sat_q16(p_hi_q);

  always_comb begin
    if (t_lo < t_hi) begin
      res_d.t_near = t_lo;
      res_d.t_far  = t_hi;
    end else begin
      res_d.t_near = t_hi;
      res_d.t_far  = t_lo;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_lo_q <= d_lo_d;
      d_hi_q <= d_hi_d;
      inv_q  <= inv_dir_i;
      p_lo_q <= p_lo_d;
      p_hi_q <= p_hi_d;
      res_q  <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

FILE: hw/rtl/rbsi_merge.sv
`timescale 1ns / 1ps
`default_nettype none

// intersect the per-axis intervals and decide hit
module rbsi_merge (
  input  wire logic                clk_i,
  input  wire logic                en_i,
  input  wire rbsi_pkg::lane_res_t lane_res_i [rbsi_pkg::NumAxes],
  output logic                     hit_o,
  output rbsi_pkg::q16_t           dist_o
);

  rbsi_pkg::q16_t t_enter, t_exit;
  logic           hit_d, hit_q;
  rbsi_pkg::q16_t dist_d, dist_q;

  always_comb begin
    t_enter = lane_res_i[0].t_near;
    t_exit  = lane_res_i[0].t_far;
    for (int unsigned i = 1; i < rbsi_pkg::NumAxes; i++) begin
      if (lane_res_i[i].t_near > t_enter) t_enter = lane_res_i[i].t_near;
      if (lane_res_i[i].t_far < t_exit)   t_exit  = lane_res_i[i].t_far;
    end
  end

  always_comb begin
    hit_d  = ~((t_exit < t_enter) | t_exit[rbsi_pkg::QW-1]);
    dist_d = '0;
    if (hit_d) begin
      dist_d = (t_enter > 0) ? t_enter : t_exit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hit_q  <= hit_d;
      dist_q <= dist_d;
    end
  end

  assign hit_o  = hit_q;
  assign dist_o = dist_q;

endmodule

`default_nettype wire

FILE: hw/rtl/ray_box_slab_intersect.sv
// Ray versus axis-aligned box test, slab method, signed Q16.16.
// in_i carries one ray (origin, inverse direction) and one box per word;
// out_o returns hit and hit_distance (0 on a miss), one word per input word.
// Both channels use valid/ready; a word moves when both are high.
// Three axis lanes run side by side, each with a subtract stage, a
// 33x32 multiply stage and a rescale/saturate/order stage; a merge stage
// intersects the intervals and registers the result.
// Throughput: one word per cycle while out_o is not stalled; the four stages advance together.
// When out_o stalls with a word waiting, the whole pipe holds and in_i.ready
// drops in the same cycle; ready returns as soon as the output word is taken,
// so new words keep entering while the output register still holds a word
// that is being taken.
// Reset clears the stage valid bits only; out_o.valid is low after reset.
`timescale 1ns / 1ps
`default_nettype none

module ray_box_slab_intersect (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  rbsi_in_if.sink     in_i,
  rbsi_out_if.source  out_o
);

  localparam int unsigned Stages = 4;

  logic                 en;
  logic [Stages-1:0]    vld_d, vld_q;
  rbsi_pkg::lane_res_t  lane_res [rbsi_pkg::NumAxes];

  // global advance: pipe moves unless a finished word is blocked
  assign en         = ~vld_q[Stages-1] | out_o.ready;
  assign in_i.ready = en;
  assign vld_d      = {vld_q[Stages-2:0], in_i.valid};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= vld_d;
    end
  end

  rbsi_lane u_lane_x (
    .clk_i     (clk_i),
    .en_i      (en),
    .origin_i  (in_i.origin_x),
    .inv_dir_i (in_i.inv_dir_x),
    .box_min_i (in_i.box_min_x),
    .box_max_i (in_i.box_max_x),
    .res_o     (lane_res[0])
  );

  rbsi_lane u_lane_y (
    .clk_i     (clk_i),
    .en_i      (en),
    .origin_i  (in_i.origin_y),
    .inv_dir_i (in_i.inv_dir_y),
    .box_min_i (in_i.box_min_y),
    .box_max_i (in_i.box_max_y),
    .res_o     (lane_res[1])
  );

  rbsi_lane u_lane_z (
    .clk_i     (clk_i),
    .en_i      (en),
    .origin_i  (in_i.origin_z),
    .inv_dir_i (in_i.inv_dir_z),
    .box_min_i (in_i.box_min_z),
    .box_max_i (in_i.box_max_z),
    .res_o     (lane_res[2])
  );

  rbsi_merge u_merge (
    .clk_i      (clk_i),
    .en_i       (en),
    .lane_res_i (lane_res),
    .hit_o      (out_o.hit),
    .dist_o     (out_o.hit_distance)
  );

  assign out_o.valid = vld_q[Stages-1];

endmodule

`default_nettype wire
